@@ hw/rtl/bpiou_pkg.sv @@
// ---------------------------------------------------------------------------
// Box pair IoU package
// Shared defaults and the status record that rides along the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package bpiou_pkg;

  localparam int unsigned COORD_BITS_DEF    = 16;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Per-word status carried next to the arithmetic payload.
  typedef struct packed {
    logic iou_ok;         // boxes well formed, later also union area nonzero
    logic nonzero;        // intersection area nonzero
    logic full;           // intersection equals union, IoU is exactly one
    logic a_holds_b;
    logic b_holds_a;
    logic edges_overlap;
  } bpiou_rel_t;

endpackage

`default_nettype wire

@@ hw/rtl/bpiou_geom.sv @@
// ---------------------------------------------------------------------------
// Box pair IoU: geometry stage
// Edge compares, containment flags, box extents and intersection extents.
// ---------------------------------------------------------------------------
`default_nettype none

module bpiou_geom
  import bpiou_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  output logic                       rdy_o,
  input  wire logic [COORD_BITS-1:0] ax0_i,
  input  wire logic [COORD_BITS-1:0] ay0_i,
  input  wire logic [COORD_BITS-1:0] ax1_i,
  input  wire logic [COORD_BITS-1:0] ay1_i,
  input  wire logic [COORD_BITS-1:0] bx0_i,
  input  wire logic [COORD_BITS-1:0] by0_i,
  input  wire logic [COORD_BITS-1:0] bx1_i,
  input  wire logic [COORD_BITS-1:0] by1_i,
  output logic                       vld_o,
  input  wire logic                  rdy_i,
  output logic [COORD_BITS-1:0]      wa_o,
  output logic [COORD_BITS-1:0]      ha_o,
  output logic [COORD_BITS-1:0]      wb_o,
  output logic [COORD_BITS-1:0]      hb_o,
  output logic [COORD_BITS-1:0]      wc_o,
  output logic [COORD_BITS-1:0]      hc_o,
  output bpiou_rel_t                 rel_o
);

  logic                  vld_q;
  logic [COORD_BITS-1:0] wa_q, ha_q, wb_q, hb_q, wc_q, hc_q;
  logic [COORD_BITS-1:0] wa_d, ha_d, wb_d, hb_d, wc_d, hc_d;
  logic [COORD_BITS-1:0] cx0, cy0, cx1, cy1;
  bpiou_rel_t            rel_q, rel_d;
  logic                  b_in_a, a_in_b, apart, form_ok, hit;

  always_comb begin
    b_in_a  = (bx0_i >= ax0_i) && (bx1_i <= ax1_i) && (by0_i >= ay0_i) && (by1_i <= ay1_i);
    a_in_b  = (ax0_i >= bx0_i) && (ax1_i <= bx1_i) && (ay0_i >= by0_i) && (ay1_i <= by1_i);
    apart   = (ax0_i > bx1_i) || (ax1_i < bx0_i) || (ay0_i > by1_i) || (ay1_i < by0_i);
    form_ok = !((ax0_i > ax1_i) || (ay0_i > ay1_i) || (bx0_i > bx1_i) || (by0_i > by1_i));

    cx0 = (ax0_i > bx0_i) ? ax0_i : bx0_i;
    cy0 = (ay0_i > by0_i) ? ay0_i : by0_i;
    cx1 = (ax1_i < bx1_i) ? ax1_i : bx1_i;
    cy1 = (ay1_i < by1_i) ? ay1_i : by1_i;
    hit = (cx1 >= cx0) && (cy1 >= cy0);

    // Extents of an ill-formed box wrap; the word is flagged and the IoU dropped later.
    wa_d = ax1_i - ax0_i;
    ha_d = ay1_i - ay0_i;
    wb_d = bx1_i - bx0_i;
    hb_d = by1_i - by0_i;
    wc_d = hit ? (cx1 - cx0) : '0;
    hc_d = hit ? (cy1 - cy0) : '0;

    rel_d               = '0;
    rel_d.iou_ok        = form_ok;
    rel_d.a_holds_b     = b_in_a;
    rel_d.b_holds_a     = a_in_b;
    rel_d.edges_overlap = !b_in_a && !a_in_b && !apart;
  end

  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      wa_q  <= wa_d;
      ha_q  <= ha_d;
      wb_q  <= wb_d;
      hb_q  <= hb_d;
      wc_q  <= wc_d;
      hc_q  <= hc_d;
      rel_q <= rel_d;
    end
  end

  assign vld_o = vld_q;
  assign wa_o  = wa_q;
  assign ha_o  = ha_q;
  assign wb_o  = wb_q;
  assign hb_o  = hb_q;
  assign wc_o  = wc_q;
  assign hc_o  = hc_q;
  assign rel_o = rel_q;

endmodule

`default_nettype wire

@@ hw/rtl/bpiou_area.sv @@
// ---------------------------------------------------------------------------
// Box pair IoU: area stages
// Stage one multiplies out the three areas, stage two forms the union area
// and classifies the word for the divider.
// ---------------------------------------------------------------------------
`default_nettype none

module bpiou_area
  import bpiou_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned AreaBits  = 2 * COORD_BITS,
  localparam int unsigned UnionBits = AreaBits + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  vld_i,
  output logic                       rdy_o,
  input  wire logic [COORD_BITS-1:0] wa_i,
  input  wire logic [COORD_BITS-1:0] ha_i,
  input  wire logic [COORD_BITS-1:0] wb_i,
  input  wire logic [COORD_BITS-1:0] hb_i,
  input  wire logic [COORD_BITS-1:0] wc_i,
  input  wire logic [COORD_BITS-1:0] hc_i,
  input  wire bpiou_rel_t            rel_i,
  output logic                       vld_o,
  input  wire logic                  rdy_i,
  output logic [UnionBits-1:0]       inter_o,
  output logic [UnionBits-1:0]       union_o,
  output bpiou_rel_t                 rel_o
);

  // Product stage.
  logic                vp_q;
  logic                rdy_p;
  logic [AreaBits-1:0] area_a_q, area_b_q, inter_q;
  bpiou_rel_t          relp_q;

  // Sum stage.
  logic                 vs_q;
  logic [UnionBits-1:0] union_d, union_q, inter_s_q;
  bpiou_rel_t           rels_d, rels_q;

  assign rdy_p = !vs_q || rdy_i;
  assign rdy_o = !vp_q || rdy_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
      vs_q <= 1'b0;
    end else begin
      if (rdy_o) begin
        vp_q <= vld_i;
      end
      if (rdy_p) begin
        vs_q <= vp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      area_a_q <= AreaBits'(wa_i * ha_i);
      area_b_q <= AreaBits'(wb_i * hb_i);
      inter_q  <= AreaBits'(wc_i * hc_i);
      relp_q   <= rel_i;
    end
  end

  always_comb begin
    union_d = UnionBits'({1'b0, area_a_q}) + UnionBits'({1'b0, area_b_q})
            - UnionBits'({1'b0, inter_q});
    rels_d         = relp_q;
    rels_d.iou_ok  = relp_q.iou_ok && (union_d != '0);
    rels_d.nonzero = (inter_q != '0);
    rels_d.full    = (UnionBits'({1'b0, inter_q}) >= union_d);
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && vp_q) begin
      union_q   <= union_d;
      inter_s_q <= UnionBits'({1'b0, inter_q});
      rels_q    <= rels_d;
    end
  end

  assign vld_o   = vs_q;
  assign inter_o = inter_s_q;
  assign union_o = union_q;
  assign rel_o   = rels_q;

endmodule

`default_nettype wire

@@ hw/rtl/bpiou_div_step.sv @@
// ---------------------------------------------------------------------------
// Box pair IoU: divider step
// One restoring step of the fraction divide, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module bpiou_div_step
  import bpiou_pkg::*;
#(
  parameter int unsigned DEN_BITS = 2 * COORD_BITS_DEF + 1,
  parameter int unsigned QUO_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  output logic                     rdy_o,
  input  wire logic [DEN_BITS-1:0] rem_i,
  input  wire logic [DEN_BITS-1:0] den_i,
  input  wire logic [QUO_BITS-1:0] quo_i,
  input  wire bpiou_rel_t          rel_i,
  output logic                     vld_o,
  input  wire logic                rdy_i,
  output logic [DEN_BITS-1:0]      rem_o,
  output logic [DEN_BITS-1:0]      den_o,
  output logic [QUO_BITS-1:0]      quo_o,
  output bpiou_rel_t               rel_o
);

  logic                vld_q;
  logic [DEN_BITS:0]   twice, diff;
  logic                take;
  logic [DEN_BITS-1:0] rem_d, rem_q, den_q;
  logic [QUO_BITS-1:0] quo_q;
  bpiou_rel_t          rel_q;

  // The remainder stays below the divisor, so the doubled value fits one more bit.
  always_comb begin
    twice = {rem_i, 1'b0};
    diff  = twice - {1'b0, den_i};
    take  = (twice >= {1'b0, den_i});
    rem_d = take ? diff[DEN_BITS-1:0] : twice[DEN_BITS-1:0];
  end

  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= {quo_i[QUO_BITS-2:0], take};
      rel_q <= rel_i;
    end
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;
  assign rel_o = rel_q;

endmodule

`default_nettype wire

@@ hw/rtl/box_pair_iou_relation_top.sv @@
// ---------------------------------------------------------------------------
// Box pair IoU relation, top level
// Intersection over union of two axis-aligned boxes, plus containment and
// partial-overlap flags, fully pipelined.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)
//  s_axis   | in  | a_xmin a_ymin a_xmax a_ymax b_xmin b_ymin b_xmax b_ymax
//  m_axis   | out | iou_fraction iou_valid a_holds_b b_holds_a edges_overlap
//
// One word is taken per cycle unless the output stalls. Registered stages:
// geometry, area products, union sum, then one restoring divider step per
// fraction bit, the last step register driving the output. Each stage holds its
// word while the next one is full, so a stall fills the bubbles first and nothing
// is lost. Reset clears only the stage valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module box_pair_iou_relation_top
  import bpiou_pkg::*;
#(
  parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int unsigned InBits   = ((8 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned IouBits  = FRACTION_BITS + 1,
  localparam int unsigned OutBits  = ((IouBits + 4 + 7) / 8) * 8,
  localparam int unsigned DenBits  = 2 * COORD_BITS + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // a_xmin, a_ymin, a_xmax, a_ymax, b_xmin, b_ymin, b_xmax, b_ymax
  input  wire logic [InBits-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // iou_fraction, iou_valid, a_holds_b, b_holds_a, edges_overlap, zero fill
  output logic [OutBits-1:0]      m_axis_tdata
);

  logic [COORD_BITS-1:0] wa, ha, wb, hb, wc, hc;
  logic                  g_vld, g_rdy, a_vld, a_rdy;
  bpiou_rel_t            g_rel;

  bpiou_geom #(
    .COORD_BITS(COORD_BITS)
  ) u_geom (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s_axis_tvalid),
    .rdy_o  (s_axis_tready),
    .ax0_i  (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
    .ay0_i  (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
    .ax1_i  (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
    .ay1_i  (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
    .bx0_i  (s_axis_tdata[4*COORD_BITS +: COORD_BITS]),
    .by0_i  (s_axis_tdata[5*COORD_BITS +: COORD_BITS]),
    .bx1_i  (s_axis_tdata[6*COORD_BITS +: COORD_BITS]),
    .by1_i  (s_axis_tdata[7*COORD_BITS +: COORD_BITS]),
    .vld_o  (g_vld),
    .rdy_i  (g_rdy),
    .wa_o   (wa),
    .ha_o   (ha),
    .wb_o   (wb),
    .hb_o   (hb),
    .wc_o   (wc),
    .hc_o   (hc),
    .rel_o  (g_rel)
  );

  // Divider chain; index 0 is the area stage output.
  logic                     d_vld [FRACTION_BITS+1];
  logic                     d_rdy [FRACTION_BITS+1];
  logic [DenBits-1:0]       d_rem [FRACTION_BITS+1];
  logic [DenBits-1:0]       d_den [FRACTION_BITS+1];
  logic [FRACTION_BITS-1:0] d_quo [FRACTION_BITS+1];
  bpiou_rel_t               d_rel [FRACTION_BITS+1];

  bpiou_area #(
    .COORD_BITS(COORD_BITS)
  ) u_area (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (g_vld),
    .rdy_o   (g_rdy),
    .wa_i    (wa),
    .ha_i    (ha),
    .wb_i    (wb),
    .hb_i    (hb),
    .wc_i    (wc),
    .hc_i    (hc),
    .rel_i   (g_rel),
    .vld_o   (a_vld),
    .rdy_i   (a_rdy),
    .inter_o (d_rem[0]),
    .union_o (d_den[0]),
    .rel_o   (d_rel[0])
  );

  assign d_vld[0] = a_vld;
  assign a_rdy    = d_rdy[0];
  assign d_quo[0] = '0;

  for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_step
    bpiou_div_step #(
      .DEN_BITS (DenBits),
      .QUO_BITS (FRACTION_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (d_vld[i]),
      .rdy_o  (d_rdy[i]),
      .rem_i  (d_rem[i]),
      .den_i  (d_den[i]),
      .quo_i  (d_quo[i]),
      .rel_i  (d_rel[i]),
      .vld_o  (d_vld[i+1]),
      .rdy_i  (d_rdy[i+1]),
      .rem_o  (d_rem[i+1]),
      .den_o  (d_den[i+1]),
      .quo_o  (d_quo[i+1]),
      .rel_o  (d_rel[i+1])
    );
  end

  assign d_rdy[FRACTION_BITS] = m_axis_tready;

  bpiou_rel_t         fin;
  logic [IouBits-1:0] iou;

  always_comb begin
    fin = d_rel[FRACTION_BITS];
    if (!fin.iou_ok || !fin.nonzero) begin
      iou = '0;
    end else if (fin.full) begin
      iou = {1'b1, {FRACTION_BITS{1'b0}}};
    end else begin
      iou = {1'b0, d_quo[FRACTION_BITS]};
    end
  end

  assign m_axis_tvalid = d_vld[FRACTION_BITS];
  assign m_axis_tdata  = OutBits'({fin.edges_overlap, fin.b_holds_a, fin.a_holds_b,
                                   fin.iou_ok, iou});

  // An invalid result never carries a nonzero IoU.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[IouBits] |-> m_axis_tdata[IouBits-1:0] == '0)
    else $error("invalid IoU with nonzero fraction");

  // IoU never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[IouBits-1] |-> m_axis_tdata[IouBits-2:0] == '0)
    else $error("IoU above one");

  // Partial overlap excludes containment either way.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[IouBits+3] |->
      !m_axis_tdata[IouBits+1] && !m_axis_tdata[IouBits+2])
    else $error("overlap flag set with containment");

  // An empty output stage never refuses a word from upstream, even when stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> d_rdy[FRACTION_BITS-1])
    else $error("empty output stage stalls the divider");

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// Box pair IoU relation testbench
// Streams box pairs into the block, predicts IoU, validity and containment
// flags for every accepted word, and checks each output word in order. Both
// stream sides idle at random, the receiver once stalls long enough to back
// the pipeline up, and the sender waits for the pipeline to drain three times.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
  import bpiou_pkg::*;
();

  localparam int CW      = COORD_BITS_DEF;
  localparam int FW      = FRACTION_BITS_DEF;
  localparam int CMAX    = (1 << CW) - 1;
  localparam int IN_W    = ((8 * CW + 7) / 8) * 8;
  localparam int OUT_W   = ((FW + 1 + 4 + 7) / 8) * 8;
  localparam int LATENCY = FW + 3;

  typedef struct {
    bit [FW:0] iou_fraction;
    bit        iou_valid;
    bit        a_holds_b;
    bit        b_holds_a;
    bit        edges_overlap;
  } box_rel_t;

  class pair_scoreboard;
    box_rel_t expected_rel[$];
    int       errors = 0;

    function automatic box_rel_t relate(logic [IN_W-1:0] d);
      longint unsigned c[8];
      longint unsigned area_a, area_b, inter, uni, cx0, cy0, cx1, cy1;
      bit apart;
      box_rel_t r;
      for (int i = 0; i < 8; i++) c[i] = d[CW*i +: CW];
      // c[0..3] = box A (xmin, ymin, xmax, ymax), c[4..7] = box B
      r.iou_fraction  = '0;
      r.a_holds_b     = c[4] >= c[0] && c[6] <= c[2] && c[5] >= c[1] && c[7] <= c[3];
      r.b_holds_a     = c[0] >= c[4] && c[2] <= c[6] && c[1] >= c[5] && c[3] <= c[7];
      apart           = c[0] > c[6] || c[2] < c[4] || c[1] > c[7] || c[3] < c[5];
      r.edges_overlap = !r.a_holds_b && !r.b_holds_a && !apart;
      r.iou_valid     = !(c[0] > c[2] || c[1] > c[3] || c[4] > c[6] || c[5] > c[7]);
      if (r.iou_valid) begin
        area_a = (c[2] - c[0]) * (c[3] - c[1]);
        area_b = (c[6] - c[4]) * (c[7] - c[5]);
        cx0 = (c[0] > c[4]) ? c[0] : c[4];
        cy0 = (c[1] > c[5]) ? c[1] : c[5];
        cx1 = (c[2] < c[6]) ? c[2] : c[6];
        cy1 = (c[3] < c[7]) ? c[3] : c[7];
        inter = (cx1 >= cx0 && cy1 >= cy0) ? (cx1 - cx0) * (cy1 - cy0) : 0;
        uni = area_a + area_b - inter;
        if (uni == 0) begin
          r.iou_valid = 1'b0;
        end else if (inter >= uni) begin
          r.iou_fraction = 1 << FW;
        end else if (inter != 0) begin
          r.iou_fraction = (inter << FW) / uni;
        end
      end
      return r;
    endfunction

    function void note_pair(logic [IN_W-1:0] d);
      expected_rel.insert(expected_rel.size(), relate(d));
    endfunction

    function int pending();
      return expected_rel.size();
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] w);
      box_rel_t e;
      if (expected_rel.size() == 0) begin
        $error("unexpected output word 0x%0h", w);
        errors++;
        return;
      end
      e = expected_rel.pop_front();
      compare("iou_fraction", e.iou_fraction, w[FW:0]);
      compare("iou_valid", e.iou_valid, w[FW+1]);
      compare("a_holds_b", e.a_holds_b, w[FW+2]);
      compare("b_holds_a", e.b_holds_a, w[FW+3]);
      compare("edges_overlap", e.edges_overlap, w[FW+4]);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  pair_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  bit stall_req;

  box_pair_iou_relation_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pair(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: a random hold-off before each word while rx_idle is set, and one long stall on request.
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk_i);
      end
      gap = rx_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic [IN_W-1:0] d);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_boxes(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    send_word({CW'(by1), CW'(bx1), CW'(by0), CW'(bx0),
               CW'(ay1), CW'(ax1), CW'(ay0), CW'(ax0)});
  endtask

  // Always waits for a falling edge before checking, so tvalid is never reassigned
  // within the same step.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly well-formed pairs near each other at a random scale, plus identical
  // pairs, nested pairs, ill-formed boxes and raw noise.
  function automatic logic [IN_W-1:0] random_pair();
    int mode, k, lim, aw, ah, bw, bh, ax0, ay0, bx0, by0, j, lo;
    int v[8];
    logic [IN_W-1:0] p;
    logic [CW-1:0] t;
    mode = $urandom_range(0, 9);
    if (mode == 0) return {$urandom(), $urandom(), $urandom(), $urandom()};
    k   = $urandom_range(0, CW);
    lim = (1 << k) - 1;
    aw  = $urandom_range(0, lim);
    ah  = $urandom_range(0, lim);
    ax0 = $urandom_range(0, CMAX - aw);
    ay0 = $urandom_range(0, CMAX - ah);
    case (mode)
      1: begin
        bw = aw; bh = ah; bx0 = ax0; by0 = ay0;
      end
      2: begin
        bx0 = $urandom_range(ax0, ax0 + aw);
        by0 = $urandom_range(ay0, ay0 + ah);
        bw  = $urandom_range(0, ax0 + aw - bx0);
        bh  = $urandom_range(0, ay0 + ah - by0);
      end
      default: begin
        bw  = $urandom_range(0, lim);
        bh  = $urandom_range(0, lim);
        bx0 = ax0 - bw - 1 + $urandom_range(0, aw + bw + 2);
        by0 = ay0 - bh - 1 + $urandom_range(0, ah + bh + 2);
        if (bx0 < 0) bx0 = 0;
        if (bx0 > CMAX - bw) bx0 = CMAX - bw;
        if (by0 < 0) by0 = 0;
        if (by0 > CMAX - bh) by0 = CMAX - bh;
      end
    endcase
    v = '{ax0, ay0, ax0 + aw, ay0 + ah, bx0, by0, bx0 + bw, by0 + bh};
    for (int i = 0; i < 8; i++) p[CW*i +: CW] = CW'(v[i]);
    if ($urandom_range(0, 1)) p = {p[IN_W/2-1:0], p[IN_W-1:IN_W/2]};
    if (mode == 9) begin
      // Swap min and max on one axis of one box.
      j  = $urandom_range(0, 3);
      lo = (j / 2) * 4 + (j % 2);
      t  = p[CW*lo +: CW];
      p[CW*lo +: CW] = p[CW*(lo+2) +: CW];
      p[CW*(lo+2) +: CW] = t;
    end
    return p;
  endfunction

  initial begin
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    stall_req     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pairs: zero and full-scale coordinates, identical, nested,
    // partial, disjoint, touching, ill-formed and zero-area boxes.
    send_boxes(0, 0, 0, 0, 0, 0, 0, 0);
    send_boxes(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_boxes(0, 0, CMAX, CMAX, 0, 0, CMAX, CMAX);
    send_boxes(10, 10, 20, 30, 10, 10, 20, 30);
    send_boxes(0, 0, 100, 100, 10, 10, 20, 20);
    send_boxes(10, 10, 20, 20, 0, 0, 100, 100);
    send_boxes(0, 0, 10, 10, 5, 5, 15, 15);
    send_boxes(0, 0, 10, 10, 20, 0, 30, 10);
    send_boxes(0, 0, 10, 10, 0, 20, 10, 30);
    send_boxes(0, 0, 10, 10, 10, 0, 20, 10);
    send_boxes(0, 0, 10, 10, 10, 10, 20, 20);
    send_boxes(10, 0, 5, 10, 0, 0, 20, 20);
    send_boxes(0, 10, 10, 5, 0, 0, 20, 20);
    send_boxes(0, 0, 20, 20, 10, 0, 5, 10);
    send_boxes(0, 0, 20, 20, 0, 10, 10, 5);
    send_boxes(5, 0, 5, 10, 0, 0, 10, 10);
    send_boxes(5, 0, 5, 10, 5, 2, 5, 8);
    send_boxes(0, 0, CMAX - 1, CMAX - 1, 1, 1, CMAX, CMAX);
    send_boxes(0, 0, CMAX, CMAX, 100, 100, 101, 101);
    send_boxes('h5555, 'h5555, 'haaaa, 'haaaa, 'h5555, 'haaaa, 'haaaa, 'haaaa);
    send_boxes('haaaa, 'h5555, 'h5555, 'haaaa, 1, 2, CMAX, CMAX - 2);
    drain_pipeline();

    for (int i = 0; i < 1500; i++) begin
      if (i % 150 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      // Back the pipeline up while the sender keeps offering words.
      if (i == 400) begin
        tx_idle   = 1'b0;
        stall_req = 1'b1;
      end
      if (i == 800) drain_pipeline();
      send_word(random_pair());
    end

    drain_pipeline();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
